// File: rtl/gspp_pkg.sv
package gspp_pkg;

  // Sentence framing.
  localparam int MaxSentenceLen = 100;
  localparam int CharCountW     = $clog2(MaxSentenceLen + 2);
  localparam logic [CharCountW-1:0] CharCountMax = CharCountW'(MaxSentenceLen);

  // Characters of interest.
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic [39:0] TalkerId  = "GNGGA";
  localparam logic [3:0]  TalkerLen = 4'd5;

  // Field numbers within a sentence.
  localparam logic [3:0] FieldTalker = 4'd0;
  localparam logic [3:0] FieldLat    = 4'd2;
  localparam logic [3:0] FieldLatDir = 4'd3;
  localparam logic [3:0] FieldLon    = 4'd4;
  localparam logic [3:0] FieldLonDir = 4'd5;
  localparam logic [3:0] FieldFix    = 4'd6;
  localparam logic [3:0] FieldLast   = 4'd15;
  localparam logic [3:0] PosLast     = 4'd15;

  // Degree digits and minimum field lengths.
  localparam logic [3:0] LatDegLen = 4'd2;
  localparam logic [3:0] LonDegLen = 4'd3;
  localparam logic [3:0] LatMinLen = 4'd8;
  localparam logic [3:0] LonMinLen = 4'd9;

  // Position arithmetic.
  localparam int LatW  = 30;
  localparam int LonW  = 34;
  localparam int MinQW = 25;
  localparam logic [LonW-1:0] DegE7  = 34'd10000000;
  localparam logic [LatW-1:0] LatMax = 30'd999999999;

  // Command queue.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    OP_RESTART,
    OP_DEG_DIGIT,
    OP_MIN_DIGIT,
    OP_LAT_DIR,
    OP_LON_DIR,
    OP_FIX,
    OP_NEXT_FIELD,
    OP_END
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic       close_lat;
    logic       close_lon;
  } cmd_t;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= ChZero && c <= ChNine) begin
      d = c[3:0];
    end
    return d;
  endfunction

  function automatic logic [7:0] talker_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = TalkerId[39:32];
      3'd1:    c = TalkerId[31:24];
      3'd2:    c = TalkerId[23:16];
      3'd3:    c = TalkerId[15:8];
      3'd4:    c = TalkerId[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/gspp_if.sv
interface gspp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface gspp_fix_if import gspp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            fix_valid;
  logic [LatW-1:0] latitude_e7;
  logic [LonW-1:0] longitude_e7;
  logic [7:0]      lat_hemisphere;
  logic [7:0]      lon_hemisphere;

  modport source (output valid, output fix_valid, output latitude_e7, output longitude_e7,
                  output lat_hemisphere, output lon_hemisphere, input ready);
  modport sink (input valid, input fix_valid, input latitude_e7, input longitude_e7,
                input lat_hemisphere, input lon_hemisphere, output ready);
endinterface

// File: rtl/gspp_front.sv
module gspp_front import gspp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       rx_ready_o,
  input  logic       queue_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic                  in_sentence_q, in_sentence_d;
  logic [CharCountW-1:0] char_count_q, char_count_d;
  logic [3:0]            field_q, field_d;
  logic [3:0]            pos_q, pos_d;
  logic                  talker_q, talker_d;
  logic                  accept;
  logic [3:0]            deg_len;

  assign rx_ready_o = !queue_full_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign deg_len    = (field_q == FieldLat) ? LatDegLen : LonDegLen;

  always_comb begin
    in_sentence_d   = in_sentence_q;
    char_count_d    = char_count_q;
    field_d         = field_q;
    pos_d           = pos_q;
    talker_d        = talker_q;
    push_o          = 1'b0;
    cmd_o.op        = OP_NEXT_FIELD;
    cmd_o.data      = rx_byte_i;
    cmd_o.close_lat = (field_q == FieldLat) && (pos_q >= LatMinLen);
    cmd_o.close_lon = (field_q == FieldLon) && (pos_q >= LonMinLen);

    if (accept) begin
      if (rx_byte_i == ChDollar) begin
        in_sentence_d = 1'b1;
        char_count_d  = '0;
        field_d       = '0;
        pos_d         = '0;
        talker_d      = 1'b1;
        push_o        = 1'b1;
        cmd_o.op      = OP_RESTART;
      end else if (in_sentence_q) begin
        if (rx_byte_i == ChCr) begin
          in_sentence_d = 1'b0;
          if (field_q != FieldTalker && talker_q && char_count_q <= CharCountMax) begin
            push_o   = 1'b1;
            cmd_o.op = OP_END;
          end
        end else begin
          if (char_count_q <= CharCountMax) begin
            char_count_d = char_count_q + 1'b1;
          end
          if (rx_byte_i == ChComma) begin
            if (field_q == FieldTalker && pos_q != TalkerLen) begin
              talker_d = 1'b0;
            end
            if (field_q < FieldLast) begin
              field_d = field_q + 1'b1;
            end
            pos_d    = '0;
            push_o   = 1'b1;
            cmd_o.op = OP_NEXT_FIELD;
          end else begin
            if (pos_q < PosLast) begin
              pos_d = pos_q + 1'b1;
            end
            case (field_q)
              FieldTalker: begin
                if (pos_q >= TalkerLen || rx_byte_i != talker_char(pos_q[2:0])) begin
                  talker_d = 1'b0;
                end
              end
              FieldLat, FieldLon: begin
                if (pos_q < deg_len) begin
                  push_o   = 1'b1;
                  cmd_o.op = OP_DEG_DIGIT;
                end else if (pos_q < deg_len + 4'd6 && pos_q != deg_len + 4'd2) begin
                  push_o   = 1'b1;
                  cmd_o.op = OP_MIN_DIGIT;
                end
              end
              FieldLatDir: begin
                push_o   = (pos_q == '0);
                cmd_o.op = OP_LAT_DIR;
              end
              FieldLonDir: begin
                push_o   = (pos_q == '0);
                cmd_o.op = OP_LON_DIR;
              end
              FieldFix: begin
                push_o   = (pos_q == '0);
                cmd_o.op = OP_FIX;
              end
              default: begin
                push_o = 1'b0;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sentence_q <= 1'b0;
      char_count_q  <= '0;
      field_q       <= '0;
      pos_q         <= '0;
      talker_q      <= 1'b0;
    end else begin
      in_sentence_q <= in_sentence_d;
      char_count_q  <= char_count_d;
      field_q       <= field_d;
      pos_q         <= pos_d;
      talker_q      <= talker_d;
    end
  end

endmodule

// File: rtl/gspp_queue.sv
module gspp_queue import gspp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/gspp_back.sv
module gspp_back import gspp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  cmd_t            cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            fix_valid_o,
  output logic [LatW-1:0] latitude_e7_o,
  output logic [LonW-1:0] longitude_e7_o,
  output logic [7:0]      lat_hemisphere_o,
  output logic [7:0]      lon_hemisphere_o
);

  // Degrees are kept already scaled by 1e7. Minutes are kept as quotient and
  // remainder of (thousandths of a minute * 500) / 3, so that the quotient is
  // the floored contribution of the minutes in units of 1e-7 degree.
  logic [LonW-1:0]  deg_e7_q, deg_e7_d;
  logic [MinQW-1:0] min_q_q, min_q_d;
  logic [1:0]       min_r_q, min_r_d;

  logic [LatW-1:0]  stg_lat_q, stg_lat_d;
  logic [LonW-1:0]  stg_lon_q, stg_lon_d;
  logic             stg_fix_q, stg_fix_d;
  logic [7:0]       stg_lat_dir_q, stg_lat_dir_d;
  logic [7:0]       stg_lon_dir_q, stg_lon_dir_d;

  logic [LatW-1:0]  lat_st_q, lat_st_d;
  logic [LonW-1:0]  lon_st_q, lon_st_d;
  logic             fix_st_q, fix_st_d;
  logic [7:0]       lat_dir_st_q, lat_dir_st_d;
  logic [7:0]       lon_dir_st_q, lon_dir_st_d;
  logic             out_valid_q, out_valid_d;

  logic             exec;
  logic [3:0]       digit;
  logic [4:0]       rem_sum;
  logic [7:0]       rem_scaled;
  logic [2:0]       rem_quot;
  logic [4:0]       rem_left;
  logic [LonW-1:0]  pos_sum;
  logic [LatW-1:0]  lat_val;
  logic [LatW-1:0]  lat_closed;
  logic [LonW-1:0]  lon_closed;

  assign exec  = cmd_valid_i && (cmd_i.op != OP_END || !out_valid_q || out_ready_i);
  assign pop_o = exec;
  assign digit = digit_of(cmd_i.data);

  // (10*r + 500*d) / 3 = 166*d + 3*r + (2*d + r) / 3, the last term by reciprocal.
  assign rem_sum    = {digit, 1'b0} + {3'b0, min_r_q};
  assign rem_scaled = ({3'b0, rem_sum} << 3) + ({3'b0, rem_sum} << 1) + {3'b0, rem_sum};
  assign rem_quot   = rem_scaled[7:5];
  assign rem_left   = rem_sum - ({2'b0, rem_quot} << 1) - {2'b0, rem_quot};

  assign pos_sum    = deg_e7_q + {{(LonW-MinQW){1'b0}}, min_q_q};
  assign lat_val    = (pos_sum > {{(LonW-LatW){1'b0}}, LatMax}) ? LatMax : pos_sum[LatW-1:0];
  assign lat_closed = cmd_i.close_lat ? lat_val : stg_lat_q;
  assign lon_closed = cmd_i.close_lon ? pos_sum : stg_lon_q;

  always_comb begin
    deg_e7_d      = deg_e7_q;
    min_q_d       = min_q_q;
    min_r_d       = min_r_q;
    stg_lat_d     = stg_lat_q;
    stg_lon_d     = stg_lon_q;
    stg_fix_d     = stg_fix_q;
    stg_lat_dir_d = stg_lat_dir_q;
    stg_lon_dir_d = stg_lon_dir_q;
    lat_st_d      = lat_st_q;
    lon_st_d      = lon_st_q;
    fix_st_d      = fix_st_q;
    lat_dir_st_d  = lat_dir_st_q;
    lon_dir_st_d  = lon_dir_st_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    if (exec) begin
      case (cmd_i.op)
        OP_RESTART: begin
          deg_e7_d      = '0;
          min_q_d       = '0;
          min_r_d       = '0;
          stg_lat_d     = lat_st_q;
          stg_lon_d     = lon_st_q;
          stg_fix_d     = fix_st_q;
          stg_lat_dir_d = lat_dir_st_q;
          stg_lon_dir_d = lon_dir_st_q;
        end
        OP_DEG_DIGIT: begin
          deg_e7_d = (deg_e7_q << 3) + (deg_e7_q << 1) + ({{(LonW-4){1'b0}}, digit} * DegE7);
        end
        OP_MIN_DIGIT: begin
          min_q_d = (min_q_q << 3) + (min_q_q << 1)
                  + ({{(MinQW-4){1'b0}}, digit} * MinQW'(166))
                  + ({{(MinQW-2){1'b0}}, min_r_q} << 1) + {{(MinQW-2){1'b0}}, min_r_q}
                  + {{(MinQW-3){1'b0}}, rem_quot};
          min_r_d = rem_left[1:0];
        end
        OP_LAT_DIR: begin
          stg_lat_dir_d = cmd_i.data;
        end
        OP_LON_DIR: begin
          stg_lon_dir_d = cmd_i.data;
        end
        OP_FIX: begin
          stg_fix_d = (cmd_i.data != ChZero);
        end
        OP_NEXT_FIELD: begin
          stg_lat_d = lat_closed;
          stg_lon_d = lon_closed;
          deg_e7_d  = '0;
          min_q_d   = '0;
          min_r_d   = '0;
        end
        OP_END: begin
          stg_lat_d    = lat_closed;
          stg_lon_d    = lon_closed;
          lat_st_d     = lat_closed;
          lon_st_d     = lon_closed;
          fix_st_d     = stg_fix_q;
          lat_dir_st_d = stg_lat_dir_q;
          lon_dir_st_d = stg_lon_dir_q;
          out_valid_d  = 1'b1;
        end
        default: begin
          out_valid_d = out_valid_q && !out_ready_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_e7_q      <= '0;
      min_q_q       <= '0;
      min_r_q       <= '0;
      stg_lat_q     <= '0;
      stg_lon_q     <= '0;
      stg_fix_q     <= 1'b0;
      stg_lat_dir_q <= '0;
      stg_lon_dir_q <= '0;
      lat_st_q      <= '0;
      lon_st_q      <= '0;
      fix_st_q      <= 1'b0;
      lat_dir_st_q  <= '0;
      lon_dir_st_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      deg_e7_q      <= deg_e7_d;
      min_q_q       <= min_q_d;
      min_r_q       <= min_r_d;
      stg_lat_q     <= stg_lat_d;
      stg_lon_q     <= stg_lon_d;
      stg_fix_q     <= stg_fix_d;
      stg_lat_dir_q <= stg_lat_dir_d;
      stg_lon_dir_q <= stg_lon_dir_d;
      lat_st_q      <= lat_st_d;
      lon_st_q      <= lon_st_d;
      fix_st_q      <= fix_st_d;
      lat_dir_st_q  <= lat_dir_st_d;
      lon_dir_st_q  <= lon_dir_st_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // The committed values double as the output register: they change only when
  // a sentence end executes, which waits until the previous result is taken.
  assign out_valid_o      = out_valid_q;
  assign fix_valid_o      = fix_st_q;
  assign latitude_e7_o    = lat_st_q;
  assign longitude_e7_o   = lon_st_q;
  assign lat_hemisphere_o = lat_dir_st_q;
  assign lon_hemisphere_o = lon_dir_st_q;

endmodule

// File: rtl/gga_sentence_position_parser.sv
// Throughput: one received byte per cycle; the input stalls only when the command queue
// (four entries) fills because a finished result has not been taken.
// A result is offered once the command for the carriage return has passed through the
// command queue and the back end has executed it and registered the result.
// Reset (asynchronous, active low) clears the parser state and the committed position,
// fix flag and hemisphere letters to zero; no sweep is needed after reset.
module gga_sentence_position_parser import gspp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  gspp_byte_if.sink   rx_i,
  gspp_fix_if.source  fix_o
);

  // The front end tracks sentence framing, field number and character position,
  // and checks the talker field. Each byte that affects the position result is
  // turned into a small command. The back end executes the commands: it builds
  // degrees and minutes in 1e-7 degree units digit by digit, stages values for
  // the current sentence and commits them when a valid GNGGA sentence ends.

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_push;
  logic queue_full;
  logic queue_valid;
  logic back_pop;

  gspp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_i.valid),
    .rx_byte_i    (rx_i.rx_byte),
    .rx_ready_o   (rx_i.ready),
    .queue_full_i (queue_full),
    .push_o       (front_push),
    .cmd_o        (front_cmd)
  );

  // The queue decouples the two halves so that bytes keep flowing while a
  // result waits at the output.
  gspp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  gspp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (queue_valid),
    .cmd_i            (queue_cmd),
    .pop_o            (back_pop),
    .out_valid_o      (fix_o.valid),
    .out_ready_i      (fix_o.ready),
    .fix_valid_o      (fix_o.fix_valid),
    .latitude_e7_o    (fix_o.latitude_e7),
    .longitude_e7_o   (fix_o.longitude_e7),
    .lat_hemisphere_o (fix_o.lat_hemisphere),
    .lon_hemisphere_o (fix_o.lon_hemisphere)
  );

endmodule

// File: rtl/gspp_checker.sv
module gspp_checker import gspp_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic            fix_valid_i,
  input logic [LatW-1:0] latitude_e7_i,
  input logic [LonW-1:0] longitude_e7_i,
  input logic [7:0]      lat_hemisphere_i,
  input logic [7:0]      lon_hemisphere_i
);

  // The input may only stall when a result was left waiting in the previous cycle.
  a_stall_needs_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_i) |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without a pending result");

  // A pending result holds until it is taken.
  a_result_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(fix_valid_i)
      && $stable(latitude_e7_i) && $stable(longitude_e7_i)
      && $stable(lat_hemisphere_i) && $stable(lon_hemisphere_i)))
    else $error("pending result changed before it was taken");

  // Latitude saturates at its upper limit.
  a_lat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (latitude_e7_i <= LatMax))
    else $error("latitude beyond its saturation limit");

endmodule

bind gga_sentence_position_parser gspp_checker u_gspp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (rx_i.valid),
  .in_ready_i       (rx_i.ready),
  .out_valid_i      (fix_o.valid),
  .out_ready_i      (fix_o.ready),
  .fix_valid_i      (fix_o.fix_valid),
  .latitude_e7_i    (fix_o.latitude_e7),
  .longitude_e7_i   (fix_o.longitude_e7),
  .lat_hemisphere_i (fix_o.lat_hemisphere),
  .lon_hemisphere_i (fix_o.lon_hemisphere)
);

// File: verif/tb_gga_sentence_position_parser.sv
`timescale 1ns / 100ps

module tb_gga_sentence_position_parser;
  import gspp_pkg::*;

  // Run shape. The cycle windows are counted from time zero.
  localparam int IdlePct    = 29;      // Chance, in percent, that a side idles in a cycle.
  localparam int CalmStart  = 1500;    // Neither side idles inside this window.
  localparam int CalmEnd    = 1900;
  localparam int HoldStart  = 800;     // Earliest cycle of the long receiver hold-off.
  localparam int HoldLen    = 200;
  localparam int RandBytes  = 1200;    // Random bytes to send after the directed part.
  localparam int MinFixes   = 12;      // Keep generating until this many fixes are likely.
  localparam int TailCycles = 16;      // Quiet cycles after the last expected fix.
  localparam int CycleLimit = 200000;

  localparam logic [7:0] ChDot = 8'h2E;

  // One position report, laid out as the fix channel carries it.
  typedef struct packed {
    logic            fix_valid;
    logic [LatW-1:0] latitude_e7;
    logic [LonW-1:0] longitude_e7;
    logic [7:0]      lat_hemisphere;
    logic [7:0]      lon_hemisphere;
  } fix_rec_t;

  // A byte waiting to be sent. When hold_for_fixes is set, the sender waits until
  // every fix expected so far has arrived before it offers this byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       hold_for_fixes;
  } tx_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gspp_byte_if rx_if ();
  gspp_fix_if  fix_if ();

  gga_sentence_position_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .fix_o  (fix_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  tx_byte_t tx_queue[$];
  fix_rec_t fix_expect[$];
  fix_rec_t fix_want;
  bit       hold_next;
  int       n_errors = 0;
  int       cycle_cnt = 0;
  int       hold_left = 0;
  bit       hold_done = 0;
  logic     calm;

  assign calm = (cycle_cnt >= CalmStart) && (cycle_cnt < CalmEnd);

  // ---------------------------------------------------------------------------
  // Sentence parser prediction. The state mirrors the block: framing and field
  // tracking, the digit accumulators of the current field, the values staged
  // during the sentence, and the values committed by the last good sentence.
  // ---------------------------------------------------------------------------
  bit          in_sent;
  int unsigned sent_len;     // Bytes after the dollar sign, saturating just past the limit.
  logic [3:0]  field_idx;
  logic [3:0]  char_pos;
  bit          talker_ok;
  int unsigned deg_acc;
  int unsigned min_acc;      // Thousandths of a minute.
  fix_rec_t    staged;
  fix_rec_t    committed;

  function automatic int unsigned dec_val(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) begin
      return c - ChZero;
    end
    return 0;
  endfunction

  // A field ends at a comma or at the carriage return. The talker field must be
  // exactly five characters long; coordinate fields update the staged position
  // only when they carry enough characters.
  task automatic close_field();
    longint unsigned pos;
    pos = longint'(deg_acc) * DegE7 + (longint'(min_acc) * 1000) / 6;
    if (field_idx == FieldTalker) begin
      if (char_pos != TalkerLen) begin
        talker_ok = 0;
      end
    end else if (field_idx == FieldLat && char_pos >= LatMinLen) begin
      staged.latitude_e7 = (pos > LatMax) ? LatMax : pos[LatW-1:0];
    end else if (field_idx == FieldLon && char_pos >= LonMinLen) begin
      staged.longitude_e7 = pos[LonW-1:0];
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    int unsigned dlen;
    if (field_idx == FieldTalker) begin
      if (char_pos >= TalkerLen || c != TalkerId[39 - 8 * char_pos -: 8]) begin
        talker_ok = 0;
      end
    end else if (field_idx == FieldLat || field_idx == FieldLon) begin
      // Degrees come first; the character where the decimal point belongs is skipped.
      dlen = (field_idx == FieldLat) ? LatDegLen : LonDegLen;
      if (char_pos < dlen) begin
        deg_acc = deg_acc * 10 + dec_val(c);
      end else if (char_pos < dlen + 6 && char_pos != dlen + 2) begin
        min_acc = min_acc * 10 + dec_val(c);
      end
    end else if (char_pos == 0) begin
      // Only the first character of the letter and fix fields matters.
      case (field_idx)
        FieldLatDir: staged.lat_hemisphere = c;
        FieldLonDir: staged.lon_hemisphere = c;
        FieldFix:    staged.fix_valid = (c != ChZero);
        default: ;
      endcase
    end
    if (char_pos < PosLast) begin
      char_pos++;
    end
  endtask

  // Advances the prediction by one accepted byte and queues the fix it completes.
  task automatic parse_byte(input logic [7:0] c);
    if (c == ChDollar) begin
      in_sent   = 1;
      sent_len  = 0;
      field_idx = FieldTalker;
      char_pos  = '0;
      talker_ok = 1;
      deg_acc   = 0;
      min_acc   = 0;
      staged    = committed;
    end else if (in_sent) begin
      if (c == ChCr) begin
        in_sent = 0;
        if (field_idx != FieldTalker && talker_ok && sent_len <= MaxSentenceLen) begin
          close_field();
          committed = staged;
          fix_expect.push_back(committed);
        end
      end else begin
        if (sent_len <= MaxSentenceLen) begin
          sent_len++;
        end
        if (c == ChComma) begin
          close_field();
          if (field_idx < FieldLast) begin
            field_idx++;
          end
          char_pos = '0;
          deg_acc  = 0;
          min_acc  = 0;
        end else begin
          take_char(c);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building blocks.
  // ---------------------------------------------------------------------------
  task automatic put(input logic [7:0] b);
    tx_queue.push_back('{rx_byte: b, hold_for_fixes: hold_next});
    hold_next = 0;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put(s[i]);
    end
  endtask

  function automatic logic [7:0] digit_char();
    return 8'(ChZero + $urandom_range(9));
  endfunction

  // Any byte that does not change the sentence framing.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == ChDollar || c == ChCr || c == ChComma) begin
      c = digit_char();
    end
    return c;
  endfunction

  task automatic put_junk(input int unsigned max_len);
    repeat ($urandom_range(max_len)) begin
      put(($urandom_range(3) == 0) ? body_char() : digit_char());
    end
  endtask

  // A coordinate field with n_deg degree digits. Most have the usual length; some are
  // short, which keeps the previous value, and some run long. Now and then a stray
  // byte lands on a digit or on the decimal point.
  task automatic put_coord(input int unsigned n_deg);
    int unsigned len;
    int unsigned dot;
    dot = n_deg + 2;
    case ($urandom_range(9))
      0:       len = $urandom_range(dot + 4);
      1:       len = dot + 5 + $urandom_range(4);
      default: len = dot + 4;
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(24) == 0) begin
        put(body_char());
      end else if (i == dot) begin
        put(ChDot);
      end else begin
        put(digit_char());
      end
    end
  endtask

  task automatic put_dir(input string usual);
    case ($urandom_range(9))
      0:       ;
      1:       put(body_char());
      default: put(usual[$urandom_range(1)]);
    endcase
    if ($urandom_range(7) == 0) begin
      put(body_char());
    end
  endtask

  task automatic put_fix();
    case ($urandom_range(9))
      0:       ;
      1:       put(body_char());
      default: put(8'(ChZero + $urandom_range(2)));
    endcase
  endtask

  // One random sentence. Most are well-formed GNGGA sentences with random content;
  // the rest are line noise, other talkers, a bare talker field, a sentence cut short
  // after the latitude, overlong sentences, and sentences left open so that the next
  // dollar sign restarts the parse. likely_fix tells whether a fix should follow.
  task automatic gen_sentence(output bit likely_fix);
    int unsigned sel;
    sel = $urandom_range(99);
    likely_fix = 0;
    if (sel < 10) begin
      repeat ($urandom_range(24, 1)) begin
        put(8'($urandom_range(255)));
      end
      return;
    end
    put(ChDollar);
    if (sel < 18) begin
      case ($urandom_range(4))
        0:       put_str("GPGGA");
        1:       put_str("GNGG");
        2:       put_str("GNGGAA");
        3:       put_str("GNGSA");
        default: repeat (5) put(body_char());
      endcase
    end else begin
      put_str("GNGGA");
    end
    if (sel >= 18 && sel < 21) begin
      put(ChCr);
      return;
    end
    put(ChComma);
    put_junk(10);
    put(ChComma);
    put_coord(LatDegLen);
    if (sel >= 31 && sel < 35) begin
      put(ChCr);
      likely_fix = 1;
      return;
    end
    put(ChComma);
    put_dir("NS");
    put(ChComma);
    put_coord(LonDegLen);
    put(ChComma);
    put_dir("EW");
    put(ChComma);
    put_fix();
    repeat ($urandom_range(10)) begin
      put(ChComma);
      put_junk(5);
    end
    if (sel >= 21 && sel < 25) begin
      put(ChComma);
      repeat ($urandom_range(90, 50)) put(body_char());
    end
    if ($urandom_range(3) == 0) begin
      put_str($sformatf("*%02X", $urandom_range(255)));
    end
    if (sel >= 25 && sel < 31) begin
      return;
    end
    put(ChCr);
    likely_fix = (sel >= 31);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    string       lead;
    bit          got_fix;
    int unsigned n_fixes;
    int unsigned rand_end;
    bit          mid_hold_set;

    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    fix_if.ready  = 1'b0;
    hold_next     = 0;

    // Bytes outside a sentence are dropped, carriage return and the byte extremes too.
    put(ChCr);
    put(8'hFF);
    put(8'h00);
    put_str("GNGGA,");
    put(ChCr);
    // All-zero position without a fix, then the saturating latitude and largest longitude.
    put_str("$GNGGA,,0000.000,N,00000.000,E,0");
    put(ChCr);
    put_str("$GNGGA,235959,9999.999,S,99999.999,W,1");
    put(ChCr);
    // A short latitude cut by the carriage return keeps the previous position.
    put_str("$GNGGA,,12");
    put(ChCr);
    // The carriage return closes the longitude field.
    put_str("$GNGGA,,4807.038,N,01131.000");
    put(ChCr);
    // Non-digits at digit positions count as zero; hemisphere bytes with the top bit
    // set; an empty fix field keeps the old flag.
    put_str("$GNGGA,,4x07.0#8,");
    put(8'hFF);
    put_str(",0113/.000,");
    put(8'h80);
    put_str(",,");
    put(ChCr);
    // The talker must be exactly GNGGA and be followed by a comma.
    put_str("$GNGGA");
    put(ChCr);
    put_str("$GNGGAX,,1111.111");
    put(ChCr);
    put_str("$GPGGA,,2222.222");
    put(ChCr);
    put_str("$GNGG,,");
    put(ChCr);
    // A dollar sign inside a sentence restarts it.
    put_str("$GNGGA,,3333.333,N$GNGGA,,4444.444,S");
    put(ChCr);
    // Fields past the last tracked one and the checksum are ignored.
    put_str("$GNGGA,,,,,,2,,,,,,,,,,,,,,,,9*7F");
    put(ChCr);
    // A sentence at exactly the length limit yields a fix; one byte more does not.
    lead = "GNGGA,,5555.555,S,";
    for (int extra = 0; extra < 2; extra++) begin
      put(ChDollar);
      put_str(lead);
      repeat (MaxSentenceLen - lead.len() + extra) put(ChComma);
      put(ChCr);
    end

    // The sender waits for every fix before the random part, and once more halfway.
    hold_next    = 1;
    rand_end     = tx_queue.size() + RandBytes;
    mid_hold_set = 0;
    n_fixes      = 0;
    while (tx_queue.size() < rand_end || n_fixes < MinFixes) begin
      if (!mid_hold_set && tx_queue.size() >= rand_end - RandBytes / 2) begin
        hold_next    = 1;
        mid_hold_set = 1;
      end
      gen_sentence(got_fix);
      n_fixes += got_fix;
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (tx_queue.size() != 0 || rx_if.valid) @(posedge clk_i);
    while (fix_expect.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Cycle count and watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Byte driver. An accepted byte is fed to the prediction at the edge where the
  // request completes; an offered byte is held until it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        parse_byte(rx_if.rx_byte);
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (tx_queue.size() == 0) begin
          rx_if.valid <= 1'b0;
        end else if (tx_queue[0].hold_for_fixes && fix_expect.size() != 0) begin
          rx_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(99) < IdlePct) begin
          rx_if.valid <= 1'b0;
        end else begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= tx_queue[0].rx_byte;
          void'(tx_queue.pop_front());
        end
      end
    end
  end

  // Fix monitor and receiver. Every accepted fix is compared with the oldest
  // prediction. Once, while a fix is waiting, the receiver holds off for a long
  // stretch so that the command queue fills and the byte input stalls.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (fix_if.valid && fix_if.ready) begin
        if (fix_expect.size() == 0) begin
          $error("fix accepted while none was expected");
          n_errors++;
        end else begin
          fix_want = fix_expect.pop_front();
          if (fix_if.fix_valid !== fix_want.fix_valid) begin
            $error("fix_valid: expected %0d, got %0d", fix_want.fix_valid, fix_if.fix_valid);
            n_errors++;
          end
          if (fix_if.latitude_e7 !== fix_want.latitude_e7) begin
            $error("latitude_e7: expected %0d, got %0d",
                   fix_want.latitude_e7, fix_if.latitude_e7);
            n_errors++;
          end
          if (fix_if.longitude_e7 !== fix_want.longitude_e7) begin
            $error("longitude_e7: expected %0d, got %0d",
                   fix_want.longitude_e7, fix_if.longitude_e7);
            n_errors++;
          end
          if (fix_if.lat_hemisphere !== fix_want.lat_hemisphere) begin
            $error("lat_hemisphere: expected 0x%02h, got 0x%02h",
                   fix_want.lat_hemisphere, fix_if.lat_hemisphere);
            n_errors++;
          end
          if (fix_if.lon_hemisphere !== fix_want.lon_hemisphere) begin
            $error("lon_hemisphere: expected 0x%02h, got 0x%02h",
                   fix_want.lon_hemisphere, fix_if.lon_hemisphere);
            n_errors++;
          end
        end
      end

      if (hold_left != 0) begin
        fix_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && cycle_cnt >= HoldStart && fix_if.valid) begin
        fix_if.ready <= 1'b0;
        hold_left <= HoldLen;
        hold_done <= 1;
      end else if (calm) begin
        fix_if.ready <= 1'b1;
      end else begin
        fix_if.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

endmodule

// File: filelist.f
rtl/gspp_pkg.sv
rtl/gspp_if.sv
rtl/gspp_front.sv
rtl/gspp_queue.sv
rtl/gspp_back.sv
rtl/gga_sentence_position_parser.sv
rtl/gspp_checker.sv
verif/tb_gga_sentence_position_parser.sv
